[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg)

`define ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

[rtl/ccv_pkg.sv]
// Types, constants and helpers for the chunk container validator.
`default_nettype none

package ccv_pkg;

   localparam int unsigned HDR_BYTES  = 16;
   localparam int unsigned MAX_CHUNKS = 4096;

   localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

   // "CHNK"
   localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h48, 8'h4E, 8'h4B};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } ccv_byte_type;

   // 'A'..'Z', '0'..'9' or '_'
   function automatic logic tag_char_ok(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h30) && (c <= 8'h39)) ||
             (c == 8'h5F);
   endfunction

endpackage

`default_nettype wire

[rtl/ccv_parser.sv]
// Per-prefix parse state and the accept verdict for the byte being stepped.
`default_nettype none

module ccv_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ccv_pkg::ccv_byte_type item,
   input  logic [31:0]           expected_size,
   output logic                  verdict
);
   import ccv_pkg::*;

   logic [31:0] pos_ff,    pos_in;
   logic [31:0] word_ff,   word_in;
   logic [31:0] total_ff,  total_in;
   logic [31:0] count_ff,  count_in;
   logic [31:0] offset_ff, offset_in;
   logic        failed_ff, failed_in;
   logic        bad_ff,    bad_in;

   logic        active;
   logic        in_header;
   logic [31:0] rel;
   logic [3:0]  sub;
   logic [27:0] idx;
   logic [32:0] entry_end;
   logic [36:0] table_end;
   logic        size_short;
   logic        size_no_entry;

   always_comb begin
      active    = (pos_ff != POS_MAX);
      in_header = (pos_ff[31:4] == '0);
      rel       = pos_ff - 32'(HDR_BYTES);
      sub       = pos_ff[3:0];
      idx       = rel[31:4];
      word_in   = {item.data, word_ff[31:8]};
      entry_end = {1'b0, offset_ff} + {1'b0, word_in};

      pos_in    = pos_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      failed_in = failed_ff;
      bad_in    = bad_ff;

      if (active) begin
         pos_in = pos_ff + 32'd1;
         if (in_header) begin
            if ((sub[3:2] == 2'b00) && (item.data != MAGIC[sub[1:0]])) begin
               failed_in = 1'b1;
            end
            if (sub == 4'd7) begin
               total_in = word_in;
            end
            if (sub == 4'd11) begin
               count_in = word_in;
            end
         end else begin
            if (sub == 4'd0) begin
               bad_in = 1'b0;
            end
            if ((sub[3:2] == 2'b00) && !tag_char_ok(item.data)) begin
               bad_in = 1'b1;
            end
            if (sub == 4'd7) begin
               offset_in = word_in;
            end
            if ((sub == 4'd15) && ({4'b0, idx} < count_ff)) begin
               if (bad_ff || (entry_end > {1'b0, total_ff})) begin
                  failed_in = 1'b1;
               end
            end
         end
      end

      // Header fields are settled once the prefix holds 16 bytes.
      table_end     = {1'b0, count_ff, 4'b0} + 37'(HDR_BYTES);
      size_short    = (pos_in[31:4] == '0);
      size_no_entry = (pos_in[31:5] == '0);

      verdict = 1'b1;
      if (size_short || failed_in) begin
         verdict = 1'b0;
      end else if (total_ff != expected_size) begin
         verdict = 1'b0;
      end else if ((count_ff == '0) || (count_ff > 32'(MAX_CHUNKS))) begin
         verdict = 1'b0;
      end else if (table_end > {5'b0, total_ff}) begin
         verdict = 1'b0;
      end else if (size_no_entry) begin
         verdict = (pos_in < expected_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         word_ff   <= '0;
         total_ff  <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         failed_ff <= 1'b0;
         bad_ff    <= 1'b0;
      end else if (step) begin
         if (item.last) begin
            pos_ff    <= '0;
            word_ff   <= '0;
            total_ff  <= '0;
            count_ff  <= '0;
            offset_ff <= '0;
            failed_ff <= 1'b0;
            bad_ff    <= 1'b0;
         end else begin
            pos_ff    <= pos_in;
            word_ff   <= active ? word_in : word_ff;
            total_ff  <= total_in;
            count_ff  <= count_in;
            offset_ff <= offset_in;
            failed_ff <= failed_in;
            bad_ff    <= bad_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/chunk_container_validator_top.sv]
// Top level of the chunk container validator: handshakes, registers, config.
//
//   channel  ports                          moves
//   req      req_valid/req_ready            one prefix byte and its last flag
//   rsp      rsp_valid/rsp_ready            accept verdict for a finished prefix
//   csr      csr_wr_en/csr_wr_data          file size, written without wait
//
// One item per cycle, but a last byte holds the input register while the
// result register keeps an untaken verdict. An item in the input register
// updates the parse state and verdict when stepped, and a stepped last byte
// loads its verdict into the result register. Synchronous reset clears all
// control and parse state and the file size; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module chunk_container_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_container,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import ccv_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   ccv_byte_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_is_container_ff;
   logic [31:0]  expected_size_ff;

   logic         out_free;
   logic         s1_go;
   logic         req_take;
   logic         verdict;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      s1_go    = s1_valid_ff && (!s1_item_ff.last || out_free);
      req_take = req_valid && req_ready;

      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_item_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready        = !s1_valid_ff || s1_go;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_container = rsp_is_container_ff;

   ccv_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_go),
      .item          (s1_item_ff),
      .expected_size (expected_size_ff),
      .verdict       (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         expected_size_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expected_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.data <= req_data_byte;
         s1_item_ff.last <= req_last_byte;
      end
      if (s1_go && s1_item_ff.last) begin
         rsp_is_container_ff <= verdict;
      end
   end

   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, s1_go && s1_item_ff.last, rsp_valid_ff,
                "last item lost its verdict")
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready,
                   !(s1_go && s1_item_ff.last), "pending verdict overwritten")
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_ready,
                   s1_valid_ff && s1_item_ff.last && !out_free, "input stalled without cause")

endmodule

`default_nettype wire
